// ===== hw/rtl/bitmap_glyph_quad_generator_defines.svh =====
// Assertion macros for the bitmap glyph quad generator.
`ifndef BITMAP_GLYPH_QUAD_GENERATOR_DEFINES_SVH
`define BITMAP_GLYPH_QUAD_GENERATOR_DEFINES_SVH

// Same-cycle implication, disabled while reset is high.
`define BGQ_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, disabled while reset is high.
`define BGQ_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

// Next-cycle implication that also holds across reset.
`define BGQ_ASSERT_NEXT_ALWAYS(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) else $error(msg);

`endif

// ===== hw/rtl/bgq_pkg.sv =====
// Shared types, constants, glyph ROM and saturation helpers for the glyph quad generator.
`default_nettype none
package bgq_pkg;

  localparam int GLYPH_COLS  = 5;
  localparam int GLYPH_ROWS  = 7;
  localparam int MASK_W      = GLYPH_COLS * GLYPH_ROWS;
  localparam int ROW_W       = 3;
  localparam int COL_W       = 3;
  localparam int GLYPH_IDX_W = 5;
  localparam int COORD_W     = 16;
  localparam int SCALE_W     = 12;
  localparam int CFG_IDX_W   = 2;
  localparam int QUEUE_DEPTH = 4;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_X    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_Y    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_PIXEL_SCALE = 2'd2;

  localparam logic signed [COORD_W-1:0] ORIGIN_RESET = 16'sd0;
  localparam logic [SCALE_W-1:0]        SCALE_RESET  = 12'd16;

  typedef struct packed {
    logic signed [COORD_W-1:0] origin_x;
    logic signed [COORD_W-1:0] origin_y;
    logic [SCALE_W-1:0]        pixel_scale;
  } cfg_t;

  // One drawable character handed from the front end to the back end.
  typedef struct packed {
    logic [GLYPH_IDX_W-1:0]    glyph;
    logic signed [COORD_W-1:0] pen;
  } qent_t;

  typedef struct packed {
    logic                   hit;
    logic [GLYPH_IDX_W-1:0] glyph;
  } lookup_t;

  // Fold lower case and map a character code to its ROM slot.
  function automatic lookup_t glyph_lookup(input logic [7:0] ch);
    logic [7:0] up;
    lookup_t    res;
    up = ch;
    if (ch >= 8'h61 && ch <= 8'h7A) up = ch - 8'h20;
    res.hit = 1'b1;
    res.glyph = '0;
    unique case (up)
      8'h46: res.glyph = 5'd0;   // F
      8'h50: res.glyph = 5'd1;   // P
      8'h53: res.glyph = 5'd2;   // S
      8'h3A: res.glyph = 5'd3;   // colon
      8'h30: res.glyph = 5'd4;
      8'h31: res.glyph = 5'd5;
      8'h32: res.glyph = 5'd6;
      8'h33: res.glyph = 5'd7;
      8'h34: res.glyph = 5'd8;
      8'h35: res.glyph = 5'd9;
      8'h36: res.glyph = 5'd10;
      8'h37: res.glyph = 5'd11;
      8'h38: res.glyph = 5'd12;
      8'h39: res.glyph = 5'd13;
      8'h58: res.glyph = 5'd14;  // X
      8'h59: res.glyph = 5'd15;  // Y
      8'h5A: res.glyph = 5'd16;  // Z
      8'h20: res.glyph = 5'd17;  // space
      8'h2D: res.glyph = 5'd18;  // minus
      8'h2C: res.glyph = 5'd19;  // comma
      default: res.hit = 1'b0;
    endcase
    return res;
  endfunction

  // Glyph bitmap, row 0 in the top five bits, column 0 at the MSB of each row.
  function automatic logic [MASK_W-1:0] glyph_rows(input logic [GLYPH_IDX_W-1:0] idx);
    logic [MASK_W-1:0] m;
    unique case (idx)
      5'd0:  m = {5'h1F, 5'h10, 5'h10, 5'h1E, 5'h10, 5'h10, 5'h10};
      5'd1:  m = {5'h1E, 5'h11, 5'h11, 5'h1E, 5'h10, 5'h10, 5'h10};
      5'd2:  m = {5'h0F, 5'h10, 5'h10, 5'h0E, 5'h01, 5'h01, 5'h1E};
      5'd3:  m = {5'h00, 5'h0C, 5'h0C, 5'h00, 5'h0C, 5'h0C, 5'h00};
      5'd4:  m = {5'h0E, 5'h11, 5'h13, 5'h15, 5'h19, 5'h11, 5'h0E};
      5'd5:  m = {5'h04, 5'h0C, 5'h04, 5'h04, 5'h04, 5'h04, 5'h0E};
      5'd6:  m = {5'h0E, 5'h11, 5'h01, 5'h02, 5'h04, 5'h08, 5'h1F};
      5'd7:  m = {5'h0E, 5'h11, 5'h01, 5'h06, 5'h01, 5'h11, 5'h0E};
      5'd8:  m = {5'h02, 5'h06, 5'h0A, 5'h12, 5'h1F, 5'h02, 5'h02};
      5'd9:  m = {5'h1F, 5'h10, 5'h1E, 5'h01, 5'h01, 5'h11, 5'h0E};
      5'd10: m = {5'h06, 5'h08, 5'h10, 5'h1E, 5'h11, 5'h11, 5'h0E};
      5'd11: m = {5'h1F, 5'h01, 5'h02, 5'h04, 5'h04, 5'h04, 5'h04};
      5'd12: m = {5'h0E, 5'h11, 5'h11, 5'h0E, 5'h11, 5'h11, 5'h0E};
      5'd13: m = {5'h0E, 5'h11, 5'h11, 5'h0F, 5'h01, 5'h02, 5'h0C};
      5'd14: m = {5'h11, 5'h11, 5'h0A, 5'h04, 5'h0A, 5'h11, 5'h11};
      5'd15: m = {5'h11, 5'h11, 5'h0A, 5'h04, 5'h04, 5'h04, 5'h04};
      5'd16: m = {5'h1F, 5'h01, 5'h02, 5'h04, 5'h08, 5'h10, 5'h1F};
      5'd18: m = {5'h00, 5'h00, 5'h00, 5'h1F, 5'h00, 5'h00, 5'h00};
      5'd19: m = {5'h00, 5'h00, 5'h00, 5'h00, 5'h00, 5'h0C, 5'h08};
      default: m = '0;  // space and unused slots
    endcase
    return m;
  endfunction

  function automatic logic signed [18:0] sx19(input logic signed [COORD_W-1:0] v);
    return {{3{v[COORD_W-1]}}, v};
  endfunction

  function automatic logic signed [18:0] ux19(input logic [14:0] v);
    return {4'b0, v};
  endfunction

  function automatic logic signed [COORD_W-1:0] sat16(input logic signed [18:0] v);
    if (v > 19'sd32767) return 16'sh7FFF;
    else if (v < -19'sd32768) return 16'sh8000;
    else return v[COORD_W-1:0];
  endfunction

endpackage
`default_nettype wire

// ===== hw/rtl/bgq_ifs.sv =====
// Valid/ready channel interfaces: character input, quad output, configuration write.
`default_nettype none
interface bgq_char_if;
  logic       valid;
  logic       ready;
  logic [7:0] character;
  logic       first_of_string;
  modport source (output valid, output character, output first_of_string, input ready);
  modport sink   (input valid, input character, input first_of_string, output ready);
endinterface

interface bgq_quad_if;
  logic                                valid;
  logic                                ready;
  logic signed [bgq_pkg::COORD_W-1:0]  quad_left;
  logic signed [bgq_pkg::COORD_W-1:0]  quad_top;
  logic signed [bgq_pkg::COORD_W-1:0]  quad_right;
  logic signed [bgq_pkg::COORD_W-1:0]  quad_bottom;
  logic                                last_quad;
  modport source (output valid, output quad_left, output quad_top, output quad_right,
                  output quad_bottom, output last_quad, input ready);
  modport sink   (input valid, input quad_left, input quad_top, input quad_right,
                  input quad_bottom, input last_quad, output ready);
endinterface

interface bgq_cfg_if;
  logic                               valid;
  logic                               ready;
  logic [bgq_pkg::CFG_IDX_W-1:0]      index;
  logic [bgq_pkg::COORD_W-1:0]        data;
  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface
`default_nettype wire

// ===== hw/rtl/bgq_front.sv =====
// Front end: accepts characters, tracks the pen and queues only drawable glyphs.
`default_nettype none
module bgq_front (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire bgq_pkg::cfg_t  cfg,
  bgq_char_if.sink            chars,
  output logic                push_valid,
  input  wire logic           push_ready,
  output bgq_pkg::qent_t      push_data
);

  logic signed [bgq_pkg::COORD_W-1:0] pen;
  logic signed [bgq_pkg::COORD_W-1:0] pen_start;
  logic signed [bgq_pkg::COORD_W-1:0] pen_next;
  logic [14:0]                        advance;
  bgq_pkg::lookup_t                   lk;
  logic                               drawable;

  // Pen advance of six pixels: 4*scale + 2*scale.
  assign advance   = {1'b0, cfg.pixel_scale, 2'b00} + {2'b00, cfg.pixel_scale, 1'b0};
  assign pen_start = chars.first_of_string ? cfg.origin_x : pen;
  assign pen_next  = bgq_pkg::sat16(bgq_pkg::sx19(pen_start) + bgq_pkg::ux19(advance));

  assign lk       = bgq_pkg::glyph_lookup(chars.character);
  assign drawable = lk.hit && (bgq_pkg::glyph_rows(lk.glyph) != '0);

  // Blank and unknown characters take a transfer but are dropped here.
  assign chars.ready     = push_ready;
  assign push_valid      = chars.valid && drawable;
  assign push_data.glyph = lk.glyph;
  assign push_data.pen   = pen_start;

  always_ff @(posedge clk) begin
    if (rst) begin
      pen <= bgq_pkg::ORIGIN_RESET;
    end else if (chars.valid && chars.ready) begin
      pen <= pen_next;
    end
  end

endmodule
`default_nettype wire

// ===== hw/rtl/bgq_fifo.sv =====
// Small queue of drawable characters between the front and back ends.
`default_nettype none
module bgq_fifo #(
  parameter int DEPTH = bgq_pkg::QUEUE_DEPTH
) (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           push_valid,
  output logic                push_ready,
  input  wire bgq_pkg::qent_t push_data,
  output logic                pop_valid,
  input  wire logic           pop_ready,
  output bgq_pkg::qent_t      pop_data
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  bgq_pkg::qent_t   slots [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic             do_push;
  logic             do_pop;

  assign push_ready = (count != CNT_W'(DEPTH));
  assign pop_valid  = (count != '0);
  assign pop_data   = slots[rd_ptr];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule
`default_nettype wire

// ===== hw/rtl/bgq_back.sv =====
// Back end: scans a glyph's set pixels and emits one saturated quad per pixel.
`default_nettype none
module bgq_back (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire bgq_pkg::cfg_t  cfg,
  input  wire logic           pop_valid,
  output logic                pop_ready,
  input  wire bgq_pkg::qent_t pop_data,
  bgq_quad_if.source          quads
);

  localparam int MW = bgq_pkg::MASK_W;

  // Pixels of the current glyph still to emit.
  logic [MW-1:0]                      mask;
  logic [MW-1:0]                      sel;
  logic [MW-1:0]                      mask_clr;
  logic signed [bgq_pkg::COORD_W-1:0] cur_pen;
  logic                               found;
  logic [bgq_pkg::ROW_W-1:0]          f_row;
  logic [bgq_pkg::COL_W-1:0]          f_col;
  logic                               adv;

  // Scan stage.
  logic                               s1_valid;
  logic [bgq_pkg::ROW_W-1:0]          s1_row;
  logic [bgq_pkg::COL_W-1:0]          s1_col;
  logic signed [bgq_pkg::COORD_W-1:0] s1_pen;
  logic                               s1_last;

  // Corner stage.
  logic                               s2_valid;
  logic signed [bgq_pkg::COORD_W-1:0] s2_x0;
  logic signed [bgq_pkg::COORD_W-1:0] s2_y0;
  logic                               s2_last;

  logic                               o_valid;
  logic [14:0]                        col_off;
  logic [14:0]                        row_off;

  always_comb begin
    found = 1'b0;
    f_row = '0;
    f_col = '0;
    sel   = '0;
    for (int r = 0; r < bgq_pkg::GLYPH_ROWS; r++) begin
      for (int c = 0; c < bgq_pkg::GLYPH_COLS; c++) begin
        if (!found && mask[MW-1-(r*bgq_pkg::GLYPH_COLS+c)]) begin
          found = 1'b1;
          f_row = bgq_pkg::ROW_W'(r);
          f_col = bgq_pkg::COL_W'(c);
          sel[MW-1-(r*bgq_pkg::GLYPH_COLS+c)] = 1'b1;
        end
      end
    end
    mask_clr = mask & ~sel;
  end

  // Advance the whole pipe unless the output holds a stalled quad.
  assign adv       = !o_valid || quads.ready;
  assign pop_ready = adv && !found;

  assign col_off = {12'b0, s1_col} * {3'b0, cfg.pixel_scale};
  assign row_off = {12'b0, s1_row} * {3'b0, cfg.pixel_scale};

  always_ff @(posedge clk) begin
    if (rst) begin
      mask     <= '0;
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
      o_valid  <= 1'b0;
    end else if (adv) begin
      s1_valid <= found;
      s2_valid <= s1_valid;
      o_valid  <= s2_valid;
      if (found) begin
        mask <= mask_clr;
      end else if (pop_valid) begin
        mask <= bgq_pkg::glyph_rows(pop_data.glyph);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      if (!found && pop_valid) begin
        cur_pen <= pop_data.pen;
      end
      s1_row  <= f_row;
      s1_col  <= f_col;
      s1_pen  <= cur_pen;
      s1_last <= (mask_clr == '0);
      s2_x0   <= bgq_pkg::sat16(bgq_pkg::sx19(s1_pen) + bgq_pkg::ux19(col_off));
      s2_y0   <= bgq_pkg::sat16(bgq_pkg::sx19(cfg.origin_y) + bgq_pkg::ux19(row_off));
      s2_last <= s1_last;
      quads.quad_left   <= s2_x0;
      quads.quad_top    <= s2_y0;
      quads.quad_right  <= bgq_pkg::sat16(bgq_pkg::sx19(s2_x0)
                                          + bgq_pkg::ux19({3'b0, cfg.pixel_scale}));
      quads.quad_bottom <= bgq_pkg::sat16(bgq_pkg::sx19(s2_y0)
                                          + bgq_pkg::ux19({3'b0, cfg.pixel_scale}));
      quads.last_quad   <= s2_last;
    end
  end

  assign quads.valid = o_valid;

endmodule
`default_nettype wire

// ===== hw/rtl/bitmap_glyph_quad_generator.sv =====
// Top level of the 5x7 bitmap glyph quad generator.
// Each drawable character is queued, then the back end loads its glyph and emits one quad
// per set pixel (at most 19), taking the next glyph only after the last pixel left the scan;
// blank or unknown characters are handled in the front end only.
// Reset (rst, synchronous): empties queue and pipe, loads register reset values, pen to 0.
`default_nettype none
module bitmap_glyph_quad_generator #(
  parameter int QUEUE_DEPTH = bgq_pkg::QUEUE_DEPTH
) (
  input  wire logic  clk,
  input  wire logic  rst,
  bgq_char_if.sink   chars,
  bgq_quad_if.source quads,
  bgq_cfg_if.sink    cfg
);

  // Configuration registers. Writes must come only while the block is idle; the block does
  // not enforce this, and the front and back ends read them live without any shadowing.
  bgq_pkg::cfg_t  regs;

  // Front-to-back queue handshake.
  logic           push_valid;
  logic           push_ready;
  bgq_pkg::qent_t push_data;
  logic           pop_valid;
  logic           pop_ready;
  bgq_pkg::qent_t pop_data;

  // The register port never stalls; a transfer to an index past the list is dropped.
  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      regs.origin_x    <= bgq_pkg::ORIGIN_RESET;
      regs.origin_y    <= bgq_pkg::ORIGIN_RESET;
      regs.pixel_scale <= bgq_pkg::SCALE_RESET;
    end else if (cfg.valid && cfg.ready) begin
      unique case (cfg.index)
        bgq_pkg::REG_ORIGIN_X:    regs.origin_x    <= cfg.data;
        bgq_pkg::REG_ORIGIN_Y:    regs.origin_y    <= cfg.data;
        bgq_pkg::REG_PIXEL_SCALE: regs.pixel_scale <= cfg.data[bgq_pkg::SCALE_W-1:0];
        default: ;
      endcase
    end
  end

  // Front end: case folding, ROM lookup, pen tracking. Characters that draw
  // nothing still advance the pen but never reach the queue.
  bgq_front u_front (
    .clk        (clk),
    .rst        (rst),
    .cfg        (regs),
    .chars      (chars),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  (push_data)
  );

  // Queue that lets the front end run ahead while quads are being drained.
  bgq_fifo #(
    .DEPTH (QUEUE_DEPTH)
  ) u_fifo (
    .clk        (clk),
    .rst        (rst),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  (push_data),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_data   (pop_data)
  );

  // Back end: loads each glyph, then one quad per cycle while the output is not stalled,
  // through a scan stage, a corner stage and the output register.
  bgq_back u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg       (regs),
    .pop_valid (pop_valid),
    .pop_ready (pop_ready),
    .pop_data  (pop_data),
    .quads     (quads)
  );

endmodule
`default_nettype wire

// ===== hw/rtl/bgq_checker.sv =====
// Port-level assertions for the glyph quad generator, bound to the top level.
`default_nettype none
`include "bitmap_glyph_quad_generator_defines.svh"
module bgq_checker (
  input wire logic                               clk,
  input wire logic                               rst,
  input wire logic                               out_valid,
  input wire logic                               out_ready,
  input wire logic signed [bgq_pkg::COORD_W-1:0] quad_left,
  input wire logic signed [bgq_pkg::COORD_W-1:0] quad_top,
  input wire logic signed [bgq_pkg::COORD_W-1:0] quad_right,
  input wire logic signed [bgq_pkg::COORD_W-1:0] quad_bottom,
  input wire logic                               last_quad
);

  `BGQ_ASSERT_NEXT(a_hold, out_valid && !out_ready, out_valid && $stable(quad_left) && $stable(quad_top) && $stable(quad_right) && $stable(quad_bottom) && $stable(last_quad), "stalled quad changed")
  `BGQ_ASSERT_NEXT_ALWAYS(a_reset, rst, !out_valid, "quad valid after reset")
  `BGQ_ASSERT_IMPL(a_width, out_valid, quad_right >= quad_left, "quad right left of its left edge")
  `BGQ_ASSERT_IMPL(a_height, out_valid, quad_bottom >= quad_top, "quad bottom above its top edge")

endmodule

bind bitmap_glyph_quad_generator bgq_checker u_checker (
  .clk         (clk),
  .rst         (rst),
  .out_valid   (quads.valid),
  .out_ready   (quads.ready),
  .quad_left   (quads.quad_left),
  .quad_top    (quads.quad_top),
  .quad_right  (quads.quad_right),
  .quad_bottom (quads.quad_bottom),
  .last_quad   (quads.last_quad)
);
`default_nettype wire
